// ===== src/dual_channel_fade_dimmer_top_macros.svh =====
// Assertion macros shared by the fade dimmer RTL.
`ifndef DUAL_CHANNEL_FADE_DIMMER_TOP_MACROS_SVH
`define DUAL_CHANNEL_FADE_DIMMER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DCFD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define DCFD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dcfd_pkg.sv =====
// Types and constants of the dual channel fade dimmer.
package dcfd_pkg;

    // Field widths
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned ELAP_W  = 10;
    localparam int unsigned SET_W   = 16;
    localparam int unsigned FADE_W  = 20;
    localparam int unsigned LOCK_W  = 16;
    localparam int unsigned CNT_W   = 16;

    // Stream and register port widths
    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned PADDR_W     = 3;
    localparam int unsigned ADDR_IDX_BIT = 2;

    // Register indexes (paddr bit 2)
    localparam logic REG_FADE_SPEED = 1'b0;
    localparam logic REG_LOCKOUT    = 1'b1;

    // Reset values
    localparam logic [FADE_W-1:0] SPEED_RESET   = FADE_W'(20000);
    localparam logic [LOCK_W-1:0] LOCKOUT_RESET = LOCK_W'(1000);
    localparam logic [CNT_W-1:0]  COUNTER_MAX   = {CNT_W{1'b1}};

    // speed * elapsed, then / 1000 by reciprocal multiply (exact for < 2^30)
    localparam int unsigned PROD_W      = FADE_W + ELAP_W;
    localparam int unsigned RECIP_W     = 31;
    localparam int unsigned RECIP_SHIFT = 40;
    localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_W'(64'd1099511628);
    localparam int unsigned STEP_W      = 21;
    localparam int unsigned MS_PER_SECOND = 1000;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 2'd0,
        CMD_SET_WARM = 2'd1,
        CMD_SET_COLD = 2'd2,
        CMD_SET_BOTH = 2'd3
    } t_cmd;

    // Input tdata fields, lowest bit first: elapsed, switch, warm, cold
    typedef struct packed {
        logic [SET_W-1:0]  cold_setting_in;
        logic [SET_W-1:0]  warm_setting;
        logic              switch_level;
        logic [ELAP_W-1:0] elapsed_ms;
    } t_in_fields;

    // Output tdata fields, lowest bit first: warm, cold, lamp, toggled
    typedef struct packed {
        logic             toggled;
        logic             lamp_on;
        logic [SET_W-1:0] cold_duty;
        logic [SET_W-1:0] warm_duty;
    } t_out_fields;

    localparam int unsigned IN_FIELDS_W  = $bits(t_in_fields);
    localparam int unsigned OUT_FIELDS_W = $bits(t_out_fields);

endpackage

// ===== src/dual_channel_fade_dimmer_top.sv =====
// Dual channel fade dimmer: three-stage pipeline with lamp toggle and slew-limited duties.
//
//  port group | dir | handshake         | payload
//  s_axis     | in  | tvalid / tready   | tuser: command; tdata: elapsed, switch, settings
//  m_axis     | out | tvalid / tready   | tdata: warm duty, cold duty, lamp on, toggled
//  apb        | in  | psel/penable      | fade_speed at 0x0, switch_lockout_ms at 0x4
//
// One item per cycle sustained while m_axis_tready holds high; result tvalid comes from the result register.
// Stage one registers speed*elapsed, stage two divides by 1000 via a reciprocal
// multiply, stage three updates lamp, counter, settings and duties.
// Synchronous active-low reset clears valids, state and config; no clearing pass.
// A stalled result stays in the output register while the earlier stages still fill.
module dual_channel_fade_dimmer_top #(
    parameter int DUTY_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input item stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: [9:0] elapsed_ms, [10] switch_level, [26:11] warm_setting,
    //        [42:27] cold_setting_in, [47:43] zero
    input  logic [dcfd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // tuser: [1:0] command
    input  logic [dcfd_pkg::CMD_W-1:0]         s_axis_tuser,
    // result item stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: [15:0] warm_duty, [31:16] cold_duty, [32] lamp_on, [33] toggled,
    //        [39:34] zero
    output logic [dcfd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dcfd_pkg::PADDR_W-1:0]       paddr,
    input  logic [dcfd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [dcfd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import dcfd_pkg::*;

    localparam logic [SET_W-1:0] DUTY_MAX = SET_W'((32'd1 << DUTY_BITS) - 32'd1);

    // Config registers
    logic [FADE_W-1:0] r_fade_speed;
    logic [LOCK_W-1:0] r_lockout;

    // Pipeline registers
    logic              r_a_valid;
    t_cmd              r_a_cmd;
    t_in_fields        r_a_item;
    logic [PROD_W-1:0] r_a_prod;
    logic              r_b_valid;
    t_cmd              r_b_cmd;
    t_in_fields        r_b_item;
    logic [STEP_W-1:0] r_b_step;
    logic              r_out_valid;
    t_out_fields       r_out_data;

    // Block state
    logic                 r_lamp;
    logic [CNT_W-1:0]     r_since;
    logic [SET_W-1:0]     r_warm_store;
    logic [SET_W-1:0]     r_cold_store;
    logic [DUTY_BITS-1:0] r_warm_level;
    logic [DUTY_BITS-1:0] r_cold_level;

    // Next values
    logic                 n_lamp;
    logic [CNT_W-1:0]     n_since;
    logic [SET_W-1:0]     n_warm_store;
    logic [SET_W-1:0]     n_cold_store;
    logic [DUTY_BITS-1:0] n_warm_level;
    logic [DUTY_BITS-1:0] n_cold_level;
    logic                 n_toggled;

    logic                        w_cfg_wr;
    t_in_fields                  w_in_item;
    logic [PROD_W-1:0]           w_prod;
    logic [PROD_W+RECIP_W-1:0]   w_scaled;
    logic                        w_c_ready;
    logic                        w_b_ready;
    logic                        w_adv_a;
    logic                        w_adv_b;
    logic                        w_adv_c;
    logic [CNT_W:0]              w_sum;
    logic [CNT_W-1:0]            w_sat;
    logic                        w_tog;
    logic [DUTY_BITS-1:0]        w_warm_target;
    logic [DUTY_BITS-1:0]        w_cold_target;

    // Move a duty toward its target by at most step, landing on it if closer
    function automatic logic [DUTY_BITS-1:0] f_approach(
        input logic [DUTY_BITS-1:0] level,
        input logic [DUTY_BITS-1:0] target,
        input logic [STEP_W-1:0]    step
    );
        logic [DUTY_BITS-1:0] gap;
        logic [DUTY_BITS-1:0] res;
        gap = '0;
        res = level;
        if (target > level) begin
            gap = target - level;
            res = (STEP_W'(gap) > step) ? level + step[DUTY_BITS-1:0] : target;
        end else if (target < level) begin
            gap = level - target;
            res = (STEP_W'(gap) > step) ? level - step[DUTY_BITS-1:0] : target;
        end
        return res;
    endfunction

    // Clamp a stored setting to the duty range
    function automatic logic [DUTY_BITS-1:0] f_sat_duty(input logic [SET_W-1:0] v);
        return (v > DUTY_MAX) ? DUTY_MAX[DUTY_BITS-1:0] : v[DUTY_BITS-1:0];
    endfunction

    // APB register file
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_speed <= SPEED_RESET;
            r_lockout    <= LOCKOUT_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[ADDR_IDX_BIT])
                REG_FADE_SPEED: r_fade_speed <= pwdata[FADE_W-1:0];
                REG_LOCKOUT:    r_lockout    <= pwdata[LOCK_W-1:0];
                default:        r_lockout    <= r_lockout;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[ADDR_IDX_BIT])
            REG_FADE_SPEED: prdata = APB_DATA_W'(r_fade_speed);
            REG_LOCKOUT:    prdata = APB_DATA_W'(r_lockout);
            default:        prdata = '0;
        endcase
    end

    // Stall chain: each stage moves when the next one is empty or moving
    assign w_c_ready     = !r_out_valid || m_axis_tready;
    assign w_b_ready     = !r_b_valid || w_c_ready;
    assign s_axis_tready = !r_a_valid || w_b_ready;
    assign w_adv_a       = s_axis_tvalid && s_axis_tready;
    assign w_adv_b       = r_a_valid && w_b_ready;
    assign w_adv_c       = r_b_valid && w_c_ready;

    // Stage one: raw step product
    assign w_in_item = s_axis_tdata[IN_FIELDS_W-1:0];
    assign w_prod    = {{ELAP_W{1'b0}}, r_fade_speed} *
                       {{FADE_W{1'b0}}, w_in_item.elapsed_ms};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv_a) begin
            r_a_valid <= 1'b1;
        end else if (w_adv_b) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_a) begin
            r_a_cmd  <= t_cmd'(s_axis_tuser);
            r_a_item <= w_in_item;
            r_a_prod <= w_prod;
        end
    end

    // Stage two: divide by 1000 through the reciprocal
    assign w_scaled = {{RECIP_W{1'b0}}, r_a_prod} * {{PROD_W{1'b0}}, RECIP_MUL};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_adv_b) begin
            r_b_valid <= 1'b1;
        end else if (w_adv_c) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_b) begin
            r_b_cmd  <= r_a_cmd;
            r_b_item <= r_a_item;
            r_b_step <= w_scaled[RECIP_SHIFT +: STEP_W];
        end
    end

    // Stage three: lockout counter, toggle, targets and fade
    assign w_sum = {1'b0, r_since} + (CNT_W + 1)'(r_b_item.elapsed_ms);
    assign w_sat = w_sum[CNT_W] ? COUNTER_MAX : w_sum[CNT_W-1:0];
    assign w_tog = (w_sat > r_lockout) && (r_b_item.switch_level == r_lamp);

    always_comb begin
        n_lamp        = r_lamp;
        n_since       = r_since;
        n_warm_store  = r_warm_store;
        n_cold_store  = r_cold_store;
        n_warm_level  = r_warm_level;
        n_cold_level  = r_cold_level;
        n_toggled     = 1'b0;
        w_warm_target = '0;
        w_cold_target = '0;
        unique case (r_b_cmd)
            CMD_TICK: begin
                n_lamp        = r_lamp ^ w_tog;
                n_toggled     = w_tog;
                n_since       = w_tog ? '0 : w_sat;
                w_warm_target = n_lamp ? f_sat_duty(r_warm_store) : '0;
                w_cold_target = n_lamp ? f_sat_duty(r_cold_store) : '0;
                n_warm_level  = f_approach(r_warm_level, w_warm_target, r_b_step);
                n_cold_level  = f_approach(r_cold_level, w_cold_target, r_b_step);
            end
            CMD_SET_WARM: n_warm_store = r_b_item.warm_setting;
            CMD_SET_COLD: n_cold_store = r_b_item.cold_setting_in;
            CMD_SET_BOTH: begin
                n_warm_store = r_b_item.warm_setting;
                n_cold_store = r_b_item.cold_setting_in;
            end
            default: n_toggled = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lamp       <= 1'b0;
            r_since      <= '0;
            r_warm_store <= '0;
            r_cold_store <= '0;
            r_warm_level <= '0;
            r_cold_level <= '0;
        end else if (w_adv_c) begin
            r_lamp       <= n_lamp;
            r_since      <= n_since;
            r_warm_store <= n_warm_store;
            r_cold_store <= n_cold_store;
            r_warm_level <= n_warm_level;
            r_cold_level <= n_cold_level;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv_c) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_c) begin
            r_out_data.warm_duty <= SET_W'(n_warm_level);
            r_out_data.cold_duty <= SET_W'(n_cold_level);
            r_out_data.lamp_on   <= n_lamp;
            r_out_data.toggled   <= n_toggled;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_data);

`include "dual_channel_fade_dimmer_top_macros.svh"

    // Reciprocal divide must give the exact quotient by 1000
    `DCFD_ASSERT_NXT(a_step_exact, i_clk, i_rst_n, w_adv_b, (32'(r_b_step) * 32'(MS_PER_SECOND) <= 32'($past(r_a_prod))) && (32'($past(r_a_prod)) < 32'(r_b_step) * 32'(MS_PER_SECOND) + 32'(MS_PER_SECOND)), "step is not elapsed*speed/1000")
    // Lamp flips exactly when the result reports a toggle
    `DCFD_ASSERT_NXT(a_lamp_flag, i_clk, i_rst_n, w_adv_c, (r_lamp != $past(r_lamp)) == r_out_data.toggled, "lamp change and toggle flag disagree")
    // Set commands leave duties and lamp untouched
    `DCFD_ASSERT_NXT(a_set_hold, i_clk, i_rst_n, w_adv_c && (r_b_cmd != CMD_TICK), $stable(r_warm_level) && $stable(r_cold_level) && $stable(r_lamp), "set command moved duty or lamp")
    // With the lamp off, duties only fall
    `DCFD_ASSERT_NXT(a_off_fall, i_clk, i_rst_n, w_adv_c && !n_lamp, (r_warm_level <= $past(r_warm_level)) && (r_cold_level <= $past(r_cold_level)), "duty rose while lamp off")

endmodule

// ===== tb/sv/dual_channel_fade_dimmer_top_tb.sv =====
// Self-checking testbench for the dual channel fade dimmer: directed and random streams checked by a predictor.
module dual_channel_fade_dimmer_top_tb;
    import dcfd_pkg::*;

    localparam int unsigned LIMIT_CYCLES    = 400000;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned HOLD_OFF_CYCLES = 64;

    // Tracks lamp, lockout counter, settings and duties; queues expected result items
    class fade_book;
        logic [FADE_W-1:0] speed;
        logic [LOCK_W-1:0] lockout;
        logic              lamp;
        logic [CNT_W-1:0]  since_toggle;
        logic [SET_W-1:0]  warm_store;
        logic [SET_W-1:0]  cold_store;
        logic [SET_W-1:0]  warm_level;
        logic [SET_W-1:0]  cold_level;
        t_out_fields       expected_q[$];
        int unsigned       results_seen;

        function new();
            speed        = SPEED_RESET;
            lockout      = LOCKOUT_RESET;
            lamp         = 1'b0;
            since_toggle = '0;
            warm_store   = '0;
            cold_store   = '0;
            warm_level   = '0;
            cold_level   = '0;
            results_seen = 0;
        endfunction

        function void load_config(logic [FADE_W-1:0] new_speed, logic [LOCK_W-1:0] new_lockout);
            speed   = new_speed;
            lockout = new_lockout;
        endfunction

        // Move a duty toward its goal by at most step, landing exactly on it
        function logic [SET_W-1:0] slew_toward(logic [SET_W-1:0] lvl, logic [SET_W-1:0] goal,
                                               longint unsigned step);
            if (goal > lvl)
                return (64'(goal - lvl) > step) ? lvl + SET_W'(step) : goal;
            if (goal < lvl)
                return (64'(lvl - goal) > step) ? lvl - SET_W'(step) : goal;
            return lvl;
        endfunction

        function void note_input(t_cmd cmd, t_in_fields f);
            t_out_fields      res;
            int unsigned      total;
            longint unsigned  rate;
            longint unsigned  span;
            longint unsigned  step;
            logic [SET_W-1:0] warm_goal;
            logic [SET_W-1:0] cold_goal;
            res = '0;
            if (cmd == CMD_TICK) begin
                // saturating lockout counter, then the switch check
                total        = since_toggle + f.elapsed_ms;
                since_toggle = (total > COUNTER_MAX) ? COUNTER_MAX : CNT_W'(total);
                if (since_toggle > lockout && f.switch_level == lamp) begin
                    lamp         = ~lamp;
                    res.toggled  = 1'b1;
                    since_toggle = '0;
                end
                warm_goal  = lamp ? warm_store : '0;
                cold_goal  = lamp ? cold_store : '0;
                rate       = speed;
                span       = f.elapsed_ms;
                step       = (rate * span) / MS_PER_SECOND;
                warm_level = slew_toward(warm_level, warm_goal, step);
                cold_level = slew_toward(cold_level, cold_goal, step);
            end else begin
                if (cmd == CMD_SET_WARM || cmd == CMD_SET_BOTH)
                    warm_store = f.warm_setting;
                if (cmd == CMD_SET_COLD || cmd == CMD_SET_BOTH)
                    cold_store = f.cold_setting_in;
            end
            res.warm_duty = warm_level;
            res.cold_duty = cold_level;
            res.lamp_on   = lamp;
            expected_q.push_back(res);
        endfunction

        // Returns 1 when the item matches the oldest expectation
        function bit check_result(t_out_fields got, output string msg);
            t_out_fields want;
            msg = "";
            results_seen++;
            if (expected_q.size() == 0) begin
                msg = $sformatf("result %0d with nothing pending: %h", results_seen, got);
                return 1'b0;
            end
            want = expected_q.pop_front();
            if (got.warm_duty !== want.warm_duty)
                msg = {msg, $sformatf(" warm_duty %h/%h", got.warm_duty, want.warm_duty)};
            if (got.cold_duty !== want.cold_duty)
                msg = {msg, $sformatf(" cold_duty %h/%h", got.cold_duty, want.cold_duty)};
            if (got.lamp_on !== want.lamp_on)
                msg = {msg, $sformatf(" lamp_on %b/%b", got.lamp_on, want.lamp_on)};
            if (got.toggled !== want.toggled)
                msg = {msg, $sformatf(" toggled %b/%b", got.toggled, want.toggled)};
            if (msg != "")
                msg = $sformatf("result %0d (got/exp):%s", results_seen, msg);
            return msg == "";
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // tdata: elapsed_ms, switch_level, warm_setting, cold_setting_in, zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // tuser: command
    logic [CMD_W-1:0]       s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // tdata: warm_duty, cold_duty, lamp_on, toggled, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    fade_book    book = new();
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    bit          idling      = 1'b1;
    bit          hold_req    = 1'b0;
    bit          switch_held = 1'b1;

    dual_channel_fade_dimmer_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string msg);
        $display("ERROR: %s", msg);
        fail_count++;
    endtask

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL dual_channel_fade_dimmer_top");
            $finish;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (!book.check_result(t_out_fields'(m_axis_tdata[OUT_FIELDS_W-1:0]), msg))
                report_mismatch(msg);
        end
    end

    // Receiver: ready runs, random stall bursts, and one long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else if (idling && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    function automatic t_in_fields in_item(logic [ELAP_W-1:0] elapsed, logic sw,
                                           logic [SET_W-1:0] warm, logic [SET_W-1:0] cold);
        t_in_fields f;
        f.elapsed_ms      = elapsed;
        f.switch_level    = sw;
        f.warm_setting    = warm;
        f.cold_setting_in = cold;
        return f;
    endfunction

    // Mostly ticks with a switch held for runs, plus setting updates
    function automatic void make_item(bit long_ticks, output t_cmd cmd, output t_in_fields f);
        int unsigned pick = $urandom_range(0, 99);
        int unsigned kind = $urandom_range(0, 99);
        cmd = (pick < 65) ? CMD_TICK : t_cmd'($urandom_range(1, 3));
        if (long_ticks)
            f.elapsed_ms = ELAP_W'($urandom_range(900, 1023));
        else if (kind < 10)
            f.elapsed_ms = ELAP_W'($urandom);
        else if (kind < 75)
            f.elapsed_ms = ELAP_W'($urandom_range(0, 50));
        else
            f.elapsed_ms = ELAP_W'($urandom_range(51, 1000));
        if ($urandom_range(0, 7) == 0)
            switch_held = ~switch_held;
        f.switch_level    = ($urandom_range(0, 9) == 0) ? 1'($urandom) : switch_held;
        f.warm_setting    = ($urandom_range(0, 1) == 0) ? SET_W'($urandom)
                                                        : {SET_W{1'($urandom)}};
        f.cold_setting_in = ($urandom_range(0, 1) == 0) ? SET_W'($urandom)
                                                        : {SET_W{1'($urandom)}};
    endfunction

    // Offer one item until accepted, then maybe idle the input
    task automatic send_item(t_cmd cmd, t_in_fields f);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= IN_TDATA_W'(f);
        do @(posedge i_clk); while (!s_axis_tready);
        book.note_input(cmd, f);
        if (idling && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // One APB write, then the bus returns to idle
    task automatic reg_write(logic idx, logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << ADDR_IDX_BIT;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop offering and let every pending result come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [FADE_W-1:0] speed, logic [LOCK_W-1:0] lockout,
                             int unsigned count, bit long_ticks, bit squeeze);
        t_cmd       cmd;
        t_in_fields f;
        drain();
        reg_write(REG_FADE_SPEED, APB_DATA_W'(speed));
        reg_write(REG_LOCKOUT, APB_DATA_W'(lockout));
        book.load_config(speed, lockout);
        for (int unsigned i = 0; i < count; i++) begin
            if (squeeze && i == 20)
                hold_req = 1'b1;
            make_item(long_ticks, cmd, f);
            send_item(cmd, f);
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_TICK;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset configuration
        send_item(CMD_TICK,     in_item(10'd0,    1'b0, 16'h0000, 16'h0000));
        send_item(CMD_SET_WARM, in_item(10'h3FF,  1'b1, 16'hFFFF, 16'hFFFF));
        send_item(CMD_SET_COLD, in_item(10'h3FF,  1'b1, 16'hAAAA, 16'h1234));
        send_item(CMD_SET_BOTH, in_item(10'd0,    1'b0, 16'hFFFF, 16'hFFFF));
        // counter past lockout but switch does not match the lamp
        send_item(CMD_TICK,     in_item(10'd1023, 1'b1, 16'h0000, 16'hFFFF));
        // switch matches: lamp turns on, duties start moving
        send_item(CMD_TICK,     in_item(10'd1000, 1'b0, 16'hFFFF, 16'h0000));
        send_item(CMD_TICK,     in_item(10'd1000, 1'b0, 16'h0000, 16'h0000));
        send_item(CMD_TICK,     in_item(10'd1000, 1'b0, 16'h0000, 16'h0000));
        // large step lands on the setting
        send_item(CMD_TICK,     in_item(10'd1000, 1'b0, 16'h0000, 16'h0000));
        send_item(CMD_SET_COLD, in_item(10'h155,  1'b1, 16'h5555, 16'h0000));
        send_item(CMD_TICK,     in_item(10'd10,   1'b0, 16'h0000, 16'h0000));
        send_item(CMD_SET_WARM, in_item(10'h2AA,  1'b0, 16'h0001, 16'h0000));
        send_item(CMD_TICK,     in_item(10'd1,    1'b0, 16'h0000, 16'h0000));
        // switch matches again: lamp turns off, duties fall toward zero
        send_item(CMD_TICK,     in_item(10'd1023, 1'b1, 16'h0000, 16'h0000));
        send_item(CMD_TICK,     in_item(10'd1023, 1'b1, 16'h0000, 16'h0000));
        send_item(CMD_TICK,     in_item(10'd1023, 1'b0, 16'h0000, 16'h0000));
        send_item(CMD_TICK,     in_item(10'd1023, 1'b0, 16'h0000, 16'h0000));
        send_item(CMD_TICK,     in_item(10'd1023, 1'b0, 16'h0000, 16'h0000));
        send_item(CMD_TICK,     in_item(10'd0,    1'b1, 16'h0000, 16'h0000));

        // Random phases, one setting each
        // frozen duties, no lockout
        run_phase(20'd0, 16'd0, 120, 1'b0, 1'b0);
        // fastest fade, switch ignored for good, counter saturates
        run_phase(20'hFFFFF, 16'hFFFF, 150, 1'b1, 1'b0);
        // slowest fade, toggles only once the counter saturates
        run_phase(20'd1, 16'hFFFE, 150, 1'b1, 1'b0);
        // typical settings, with one long receiver hold-off
        run_phase(FADE_W'($urandom_range(1000, 100000)), LOCK_W'($urandom_range(0, 3000)),
                  160, 1'b0, 1'b1);
        run_phase(FADE_W'($urandom), LOCK_W'($urandom_range(0, 200)), 130, 1'b0, 1'b0);
        // back to reset values, both sides at full rate
        drain();
        idling = 1'b0;
        run_phase(SPEED_RESET, LOCKOUT_RESET, 140, 1'b0, 1'b0);

        drain();
        if (book.pending() != 0)
            report_mismatch($sformatf("%0d results never arrived", book.pending()));
        if (fail_count == 0)
            $display("PASS dual_channel_fade_dimmer_top");
        else
            $display("FAIL dual_channel_fade_dimmer_top");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/dcfd_pkg.sv
src/dual_channel_fade_dimmer_top.sv
tb/sv/dual_channel_fade_dimmer_top_tb.sv
